[src/utcep_pkg.sv]
// utcep_pkg: shared types, constants and the month table for the
// utc_date_to_epoch_seconds pipeline. No dependencies.
package utcep_pkg;

   // calendar constants
   localparam int EPOCH_YEAR = 1970;
   localparam int YEAR_BASE  = 1900;
   // leap days in years 1..EPOCH_YEAR-1
   localparam int LEAP_BASE  = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                             + (EPOCH_YEAR - 1) / 400;
   localparam logic [35:0] SECONDS_MAX = 36'hF_FFFF_FFFF;

   // request payload
   typedef struct packed {
      logic        [10:0] years_since_1900;
      logic signed [7:0]  month_index;
      logic        [4:0]  day_of_month;
      logic        [4:0]  hour;
      logic        [5:0]  minute;
      logic        [5:0]  second;
   } req_type;

   // result payload
   typedef struct packed {
      logic [35:0] epoch_seconds;
      logic        before_epoch;
   } rsp_type;

   // after month folding: full year and month 0..11
   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } fold_type;

   // day count since the epoch plus time of day
   typedef struct packed {
      logic               pre_epoch;
      logic signed [21:0] days;
      logic        [4:0]  hour;
      logic        [5:0]  minute;
      logic        [5:0]  second;
   } days_type;

   // days before the first of each month in a common year
   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] d;
      case (month)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

[src/utcep_fold.sv]
// utcep_fold: first pipeline stage, folds the signed month index into
// the year. Depends on utcep_pkg.
module utcep_fold (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  utcep_pkg::req_type in_data,
   output logic               out_valid,
   input  logic               out_stall,
   output utcep_pkg::fold_type out_data
);
   import utcep_pkg::*;

   logic [7:0]  ofs;
   logic [15:0] prod;
   logic [4:0]  quot;
   logic [7:0]  rem;
   logic        hi;
   fold_type    data_in;
   logic        valid_ff;
   fold_type    data_ff;

   // month + 128 divided by 12 through a reciprocal multiply
   assign ofs  = {~in_data.month_index[7], in_data.month_index[6:0]};
   assign prod = 16'(ofs) * 16'd171;
   assign quot = prod[15:11];
   assign rem  = ofs - 8'({quot, 3'b000}) - 8'({quot, 2'b00});
   assign hi   = (rem[3:0] >= 4'd8);

   // undo the 128 offset (10 * 12 + 8) on quotient and remainder
   always_comb begin
      data_in.year   = 12'(in_data.years_since_1900) + 12'(YEAR_BASE - 11)
                     + 12'(quot) + 12'(hi);
      data_in.month  = hi ? (rem[3:0] - 4'd8) : (rem[3:0] + 4'd4);
      data_in.mday   = in_data.day_of_month;
      data_in.hour   = in_data.hour;
      data_in.minute = in_data.minute;
      data_in.second = in_data.second;
   end

   assign in_stall = valid_ff && out_stall;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[src/utcep_days.sv]
// utcep_days: two pipeline stages, leap-year counting and the day
// count since the epoch. Depends on utcep_pkg.
module utcep_days (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  utcep_pkg::fold_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output utcep_pkg::days_type out_data
);
   import utcep_pkg::*;

   typedef struct packed {
      logic        pre_epoch;
      logic [11:0] years;
      logic [9:0]  leaps;
      logic        leap_day;
      logic [8:0]  month_days;
      logic [4:0]  mday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } year_type;

   logic [11:0] prev_year;
   logic [9:0]  prev_q4;
   logic [15:0] prev_prod;
   logic [5:0]  prev_q100;
   logic [9:0]  cur_q4;
   logic [15:0] cur_prod;
   logic [5:0]  cur_q100;
   logic [4:0]  cur_r25;
   logic        is_leap;
   year_type    year_in;
   logic        year_valid_ff;
   year_type    year_ff;
   logic        year_stall;
   logic [21:0] n365;
   days_type    days_in;
   logic        days_valid_ff;
   days_type    days_ff;

   // leap days in years 1..year-1: y/100 as (y/4)/25 by reciprocal
   assign prev_year = in_data.year - 12'd1;
   assign prev_q4   = prev_year[11:2];
   assign prev_prod = 16'(prev_q4) * 16'd41;
   assign prev_q100 = prev_prod[15:10];

   // leap test of the year itself
   assign cur_q4   = in_data.year[11:2];
   assign cur_prod = 16'(cur_q4) * 16'd41;
   assign cur_q100 = cur_prod[15:10];
   assign cur_r25  = 5'(cur_q4 - 10'(cur_q100) * 10'd25);
   assign is_leap  = (in_data.year[1:0] == 2'b00)
                   && ((cur_r25 != 5'd0) || (cur_q100[1:0] == 2'b00));

   always_comb begin
      year_in.pre_epoch  = (in_data.year < 12'(EPOCH_YEAR));
      year_in.years      = in_data.year - 12'(EPOCH_YEAR);
      year_in.leaps      = prev_q4 - 10'(prev_q100) + 10'(prev_q100[5:2]);
      year_in.leap_day   = is_leap && (in_data.month >= 4'd2);
      year_in.month_days = days_before_month(in_data.month);
      year_in.mday       = in_data.mday;
      year_in.hour       = in_data.hour;
      year_in.minute     = in_data.minute;
      year_in.second     = in_data.second;
   end

   assign year_stall = days_valid_ff && out_stall;
   assign in_stall   = year_valid_ff && year_stall;

   // year stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         year_valid_ff <= 1'b0;
      end else if (!in_stall) begin
         year_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         year_ff <= year_in;
      end
   end

   // day count, modulo 2^22 so the sum reads as signed
   assign n365 = 22'(year_ff.years) * 22'd365;

   always_comb begin
      days_in.pre_epoch = year_ff.pre_epoch;
      days_in.days      = $signed(22'(year_ff.mday) + 22'(year_ff.month_days)
                        + 22'(year_ff.leap_day) + n365 + 22'(year_ff.leaps)
                        - 22'(LEAP_BASE + 1));
      days_in.hour      = year_ff.hour;
      days_in.minute    = year_ff.minute;
      days_in.second    = year_ff.second;
   end

   // day stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         days_valid_ff <= 1'b0;
      end else if (!year_stall) begin
         days_valid_ff <= year_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!year_stall) begin
         days_ff <= days_in;
      end
   end

   assign out_valid = days_valid_ff;
   assign out_data  = days_ff;

endmodule

[src/utcep_secs.sv]
// utcep_secs: three pipeline stages scaling days to hours, minutes and
// seconds, then clamping to the result range. Depends on utcep_pkg.
module utcep_secs (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  utcep_pkg::days_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output utcep_pkg::rsp_type  out_data
);
   import utcep_pkg::*;

   typedef struct packed {
      logic               pre_epoch;
      logic signed [27:0] hours;
      logic        [5:0]  minute;
      logic        [5:0]  second;
   } hrs_type;

   typedef struct packed {
      logic               pre_epoch;
      logic signed [33:0] minutes;
      logic        [5:0]  second;
   } mins_type;

   hrs_type            hrs_in;
   logic               hrs_valid_ff;
   hrs_type            hrs_ff;
   logic               hrs_stall;
   mins_type           mins_in;
   logic               mins_valid_ff;
   mins_type           mins_ff;
   logic               mins_stall;
   logic signed [39:0] secs;
   rsp_type            rsp_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   assign mins_stall = rsp_valid_ff && out_stall;
   assign hrs_stall  = mins_valid_ff && mins_stall;
   assign in_stall   = hrs_valid_ff && hrs_stall;

   // days * 24 + hour
   always_comb begin
      hrs_in.pre_epoch = in_data.pre_epoch;
      hrs_in.hours     = 28'(in_data.days) * 28'sd24
                       + 28'($signed({1'b0, in_data.hour}));
      hrs_in.minute    = in_data.minute;
      hrs_in.second    = in_data.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hrs_valid_ff <= 1'b0;
      end else if (!in_stall) begin
         hrs_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         hrs_ff <= hrs_in;
      end
   end

   // hours * 60 + minute
   always_comb begin
      mins_in.pre_epoch = hrs_ff.pre_epoch;
      mins_in.minutes   = 34'(hrs_ff.hours) * 34'sd60
                        + 34'($signed({1'b0, hrs_ff.minute}));
      mins_in.second    = hrs_ff.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mins_valid_ff <= 1'b0;
      end else if (!hrs_stall) begin
         mins_valid_ff <= hrs_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hrs_stall) begin
         mins_ff <= mins_in;
      end
   end

   // minutes * 60 + second, clamped; zero when the year is before the epoch
   assign secs = 40'(mins_ff.minutes) * 40'sd60
               + 40'($signed({1'b0, mins_ff.second}));

   always_comb begin
      rsp_in.before_epoch = mins_ff.pre_epoch;
      if (mins_ff.pre_epoch || (secs < 40'sd0)) begin
         rsp_in.epoch_seconds = '0;
      end else if (secs > $signed({4'b0000, SECONDS_MAX})) begin
         rsp_in.epoch_seconds = SECONDS_MAX;
      end else begin
         rsp_in.epoch_seconds = secs[35:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!mins_stall) begin
         rsp_valid_ff <= mins_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!mins_stall) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

[src/utc_date_to_epoch_seconds.sv]
// utc_date_to_epoch_seconds: UTC date and time to seconds since the epoch.
// Six registered stages from an accepted request to its result (fold, year,
// days, hours, minutes, seconds); one request per cycle while the output does not stall.
// Each stage holds only while it is full and the stage after it stalls.
// Synchronous reset clears the valid bits of all six stages.
// Depends on utcep_pkg, utcep_fold, utcep_days and utcep_secs.
module utc_date_to_epoch_seconds (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  utcep_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output utcep_pkg::rsp_type rsp_data
);
   import utcep_pkg::*;

   logic     fold_valid;
   logic     fold_stall;
   fold_type fold_data;
   logic     days_valid;
   logic     days_stall;
   days_type days_data;

   // month folding
   utcep_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (fold_valid),
      .out_stall (fold_stall),
      .out_data  (fold_data)
   );

   // leap years and day count
   utcep_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fold_valid),
      .in_stall  (fold_stall),
      .in_data   (fold_data),
      .out_valid (days_valid),
      .out_stall (days_stall),
      .out_data  (days_data)
   );

   // scaling to seconds and output register
   utcep_secs u_secs (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (days_valid),
      .in_stall  (days_stall),
      .in_data   (days_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a pre-epoch year always comes out as zero seconds
   a_before_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.before_epoch) |-> (rsp_data.epoch_seconds == 36'd0))
      else $error("before_epoch result with nonzero seconds");

   // the request side stalls only when the whole pipe is full and blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && fold_valid && days_valid))
      else $error("request stalled with a free pipeline stage");

   // a stall of the request side is released only through the output
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      (req_stall && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed during a full-pipe stall");
`endif

endmodule

[tb/sv/utc_date_to_epoch_seconds_tb.sv]
// utc_date_to_epoch_seconds_tb: self-checking bench for the UTC date to epoch seconds pipeline.
// Drives directed and random dates, predicts each result and compares it in order.
// Depends on utcep_pkg and utc_date_to_epoch_seconds.
module utc_date_to_epoch_seconds_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import utcep_pkg::*;

   localparam int STUCK_LIMIT     = 1000;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int DRAIN_TAIL      = 20;
   localparam int PHASE_ITEMS     = 267;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_asked;
   int unsigned stuck_cycles;

   // expected epoch seconds, kept in request order
   class utc_epoch_scoreboard;
      rsp_type     expected_q[$];
      int unsigned mismatches;
      int unsigned requests;
      int unsigned checked;
      int unsigned before_seen;

      // days before the first of each month, common year
      function longint month_start_days(longint month);
         case (month)
            0:       return 0;
            1:       return 31;
            2:       return 59;
            3:       return 90;
            4:       return 120;
            5:       return 151;
            6:       return 181;
            7:       return 212;
            8:       return 243;
            9:       return 273;
            10:      return 304;
            default: return 334;
         endcase
      endfunction

      // leap days in years 1..y
      function longint leap_days_upto(longint y);
         return y / 4 - y / 100 + y / 400;
      endfunction

      function bit is_leap_year(longint y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      function rsp_type predict_epoch(req_type r);
         longint  year;
         longint  month;
         longint  carry;
         longint  days;
         longint  total;
         rsp_type res;
         year  = r.years_since_1900 + YEAR_BASE;
         month = $signed(r.month_index);
         // fold month into 0..11
         if (month < 0) begin
            carry = (11 - month) / 12;
            year  = year - carry;
            month = month + 12 * carry;
         end
         if (month > 11) begin
            year  = year + month / 12;
            month = month % 12;
         end
         res = '0;
         if (year < EPOCH_YEAR) begin
            res.before_epoch = 1'b1;
            return res;
         end
         days = r.day_of_month - 1 + month_start_days(month);
         if (month >= 2 && is_leap_year(year))
            days = days + 1;
         days = days + 365 * (year - EPOCH_YEAR)
              + leap_days_upto(year - 1) - leap_days_upto(EPOCH_YEAR - 1);
         total = ((days * 24 + r.hour) * 60 + r.minute) * 60 + r.second;
         // saturate at both ends
         if (total < 0)
            total = 0;
         if (total > longint'(SECONDS_MAX))
            total = longint'(SECONDS_MAX);
         res.epoch_seconds = total[35:0];
         return res;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      function void note_request(req_type r);
         expected_q.push_back(predict_epoch(r));
         requests++;
      endfunction

      task check_result(rsp_type got);
         rsp_type exp;
         if (expected_q.size() == 0) begin
            report($sformatf("result %0d/%0d with no request pending",
                             got.epoch_seconds, got.before_epoch));
         end else begin
            exp = expected_q.pop_front();
            checked++;
            if (exp.before_epoch)
               before_seen++;
            if (got.epoch_seconds !== exp.epoch_seconds)
               report($sformatf("epoch_seconds got %0d expected %0d",
                                got.epoch_seconds, exp.epoch_seconds));
            if (got.before_epoch !== exp.before_epoch)
               report($sformatf("before_epoch got %0b expected %0b",
                                got.before_epoch, exp.before_epoch));
         end
      endtask
   endclass

   utc_epoch_scoreboard sb;

   utc_date_to_epoch_seconds u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result receiver: random stall, plus long hold-offs on request
   initial begin
      int unsigned remaining;
      int unsigned hold_served;
      remaining   = 0;
      hold_served = 0;
      rsp_stall   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            remaining   = HOLD_OFF_CYCLES;
            hold_served = hold_asked;
         end
         if (remaining > 0) begin
            rsp_stall <= 1'b1;
            remaining--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // result checking and watchdog on handshake progress
   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
            $display("utc_date_to_epoch_seconds_tb: FAIL");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   function automatic req_type make_request(int y, int m, int d, int h, int mi, int s);
      req_type r;
      r.years_since_1900 = 11'(y);
      r.month_index      = 8'(m);
      r.day_of_month     = 5'(d);
      r.hour             = 5'(h);
      r.minute           = 6'(mi);
      r.second           = 6'(s);
      return r;
   endfunction

   // mostly valid dates, some near the epoch edge, the rest raw bits
   function automatic req_type random_request();
      int unsigned pick;
      req_type     r;
      pick = $urandom_range(99);
      if (pick < 65) begin
         r = make_request($urandom_range(2047, 70), $urandom_range(11), $urandom_range(31, 1),
                          $urandom_range(23), $urandom_range(59), $urandom_range(60));
         if ($urandom_range(9) == 0)
            r.month_index = 8'($urandom);
      end else if (pick < 75) begin
         r = make_request($urandom_range(72, 68), int'($urandom_range(26)) - 13,
                          $urandom_range(1), $urandom_range(31), $urandom_range(63),
                          $urandom_range(63));
      end else begin
         r = make_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      return r;
   endfunction

   // offer one request, idling at random first; returns at the accepting edge
   task automatic send_request(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(r);
   endtask

   // stop offering and wait for every expected result
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic send_random(input int unsigned count, input int unsigned hold_at);
      for (int unsigned i = 0; i < count; i++) begin
         if (i == hold_at)
            hold_asked++;
         send_request(random_request());
      end
   endtask

   initial begin
      sb            = new;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 34;
      recv_idle_pct = 76;
      hold_asked    = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: epoch start, edges of the fields, folding, leap rules
      send_request(make_request(70, 0, 1, 0, 0, 0));
      send_request(make_request(0, 0, 1, 0, 0, 0));
      send_request(make_request(69, 11, 31, 23, 59, 59));
      send_request(make_request(69, 12, 1, 0, 0, 0));
      send_request(make_request(70, -1, 31, 23, 59, 59));
      send_request(make_request(70, 0, 0, 0, 0, 0));
      send_request(make_request(70, 0, 0, 23, 59, 59));
      send_request(make_request(70, 0, 0, 31, 63, 63));
      send_request(make_request(2047, 127, 31, 31, 63, 63));
      send_request(make_request(2047, -128, 1, 0, 0, 0));
      send_request(make_request(0, 127, 1, 0, 0, 0));
      send_request(make_request(0, -128, 0, 0, 0, 0));
      send_request(make_request(100, 1, 29, 12, 0, 0));
      send_request(make_request(100, 2, 1, 0, 0, 0));
      send_request(make_request(200, 2, 1, 0, 0, 0));
      send_request(make_request(124, 2, 1, 0, 0, 0));
      send_request(make_request(123, 2, 1, 0, 0, 0));
      send_request(make_request(138, 0, 19, 3, 14, 7));
      send_request(make_request(116, 11, 31, 23, 59, 60));
      send_request(make_request(2047, 0, 1, 0, 0, 0));
      send_request(make_request(125, 24, 15, 8, 30, 0));
      send_request(make_request(125, -13, 15, 8, 30, 0));
      drain_results();

      // random, sender idles less than receiver
      send_random(PHASE_ITEMS, PHASE_ITEMS);
      drain_results();

      // random, roles swapped
      @(posedge clock);
      send_idle_pct = 76;
      recv_idle_pct = 34;
      send_random(PHASE_ITEMS, PHASE_ITEMS);
      drain_results();

      // random at full rate, with one long receiver hold-off to back up the pipe
      @(posedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(PHASE_ITEMS, 100);
      drain_results();
      repeat (DRAIN_TAIL) @(posedge clock);

      $display("covered %0d requests under three idle mixes and a %0d-cycle output hold-off",
               sb.requests, HOLD_OFF_CYCLES);
      $display("checked %0d results, %0d before the epoch, %0d mismatches",
               sb.checked, sb.before_seen, sb.mismatches);
      if (sb.mismatches == 0)
         $display("utc_date_to_epoch_seconds_tb: PASS");
      else
         $display("utc_date_to_epoch_seconds_tb: FAIL");
      $finish;
   end

endmodule

[utc_date_to_epoch_seconds.f]
src/utcep_pkg.sv
src/utcep_fold.sv
src/utcep_days.sv
src/utcep_secs.sv
src/utc_date_to_epoch_seconds.sv
tb/sv/utc_date_to_epoch_seconds_tb.sv
